FILE: rtl/core/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
package pse_pkg;

  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;
  localparam logic [7:0] SYM_ZERO = 8'h30;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_EMPTY = 3'd1,
    STS_UNDER = 3'd2,
    STS_OVER  = 3'd3,
    STS_DIVZ  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LEFT,
    ST_EXEC,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } state_t;

endpackage

FILE: rtl/core/pse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator: control, arithmetic and stack walk.
//
// The symbol channel takes one expression character per transfer, with
// end_of_expr marking the last one. Operands are pushed as symbol minus '0';
// + - * / pop two entries and push the 8-bit wrapped result. Errors are sticky
// and leave the stack unchanged. After the last character the stack is sent
// on the result channel from top to bottom, one transfer per entry, the last
// one flagged by final_entry; an empty stack gives a single result.
// An operand is pushed when accepted; +, - and * pass through ST_RD_LEFT and
// ST_EXEC for the stack RAM's registered read; / then runs the divider in
// ST_DIV, one quotient bit per cycle. Each emitted entry is one RAM read via
// ST_EMIT_RD, ST_EMIT_LD and ST_EMIT_OUT; a stalled result holds its value.
// symbol_stall is high while a character or the emit sequence is in progress.
// Reset empties the stack and clears the error; stack contents are not cleared.
module postfix_stack_evaluator
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              symbol_valid,
  output logic              symbol_stall,
  input  logic [7:0]        symbol,
  input  logic              end_of_expr,
  output logic              result_valid,
  input  logic              result_stall,
  output logic signed [7:0] value,
  output logic [2:0]        status,
  output logic              final_entry
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  status_t        err, err_next;
  logic [7:0]     op, op_next;
  logic           last, last_next;
  logic [7:0]     right_val, right_val_next;
  logic           neg, neg_next;
  logic [7:0]     dvs, dvs_next;
  logic [7:0]     rem, rem_next;
  logic [7:0]     quot, quot_next;
  logic [2:0]     div_step, div_step_next;
  logic           out_valid, out_valid_next;
  logic [7:0]     out_value, out_value_next;
  status_t        out_status, out_status_next;
  logic           out_final, out_final_next;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_rdata;

  logic           accept;
  logic           is_op;
  logic [CW-1:0]  cnt_m1;
  logic [CW-1:0]  cnt_m2;
  logic [8:0]     div_sh;
  logic [9:0]     div_diff;
  logic           div_ge;
  logic [7:0]     quot_step;
  logic [7:0]     div_res;
  logic [15:0]    prod;
  logic [7:0]     left_mag;
  logic [7:0]     right_mag;

  pse_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign symbol_stall = (state != ST_IDLE);
  assign accept       = symbol_valid && !symbol_stall;
  assign is_op        = (symbol == SYM_ADD) || (symbol == SYM_SUB) ||
                        (symbol == SYM_MUL) || (symbol == SYM_DIV);
  assign cnt_m1       = count - CW'(1);
  assign cnt_m2       = count - CW'(2);

  assign div_sh    = {rem, quot[7]};
  assign div_diff  = {1'b0, div_sh} - {2'b00, dvs};
  assign div_ge    = !div_diff[9];
  assign quot_step = {quot[6:0], div_ge};
  assign div_res   = neg ? (8'd0 - quot_step) : quot_step;

  assign prod      = 16'($signed(mem_rdata) * $signed(right_val));
  assign left_mag  = mem_rdata[7] ? (8'd0 - mem_rdata) : mem_rdata;
  assign right_mag = right_val[7] ? (8'd0 - right_val) : right_val;

  assign result_valid = out_valid;
  assign value        = out_value;
  assign status       = out_status;
  assign final_entry  = out_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      err       <= STS_OK;
      div_step  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      err       <= err_next;
      div_step  <= div_step_next;
      out_valid <= out_valid_next;
    end
    op         <= op_next;
    last       <= last_next;
    right_val  <= right_val_next;
    neg        <= neg_next;
    dvs        <= dvs_next;
    rem        <= rem_next;
    quot       <= quot_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
    out_final  <= out_final_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    err_next        = err;
    op_next         = op;
    last_next       = last;
    right_val_next  = right_val;
    neg_next        = neg;
    dvs_next        = dvs;
    rem_next        = rem;
    quot_next       = quot;
    div_step_next   = div_step;
    out_valid_next  = out_valid;
    out_value_next  = out_value;
    out_status_next = out_status;
    out_final_next  = out_final;
    mem_we          = 1'b0;
    mem_waddr       = cnt_m2[AW-1:0];
    mem_wdata       = mem_rdata;
    mem_raddr       = cnt_m1[AW-1:0];

    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_next   = symbol;
          last_next = end_of_expr;
          if (!is_op) begin
            if (count == CW'(STACK_DEPTH)) begin
              if (err == STS_OK) err_next = STS_OVER;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = count[AW-1:0];
              mem_wdata  = symbol - SYM_ZERO;
              count_next = count + CW'(1);
            end
            if (end_of_expr) state_next = ST_EMIT_RD;
          end else if (count < CW'(2)) begin
            if (err == STS_OK) err_next = STS_UNDER;
            if (end_of_expr) state_next = ST_EMIT_RD;
          end else begin
            state_next = ST_RD_LEFT;
          end
        end
      end
      ST_RD_LEFT: begin
        right_val_next = mem_rdata;
        mem_raddr      = cnt_m2[AW-1:0];
        state_next     = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = last ? ST_EMIT_RD : ST_IDLE;
        case (op)
          SYM_ADD: begin
            mem_we     = 1'b1;
            mem_wdata  = mem_rdata + right_val;
            count_next = cnt_m1;
          end
          SYM_SUB: begin
            mem_we     = 1'b1;
            mem_wdata  = mem_rdata - right_val;
            count_next = cnt_m1;
          end
          SYM_MUL: begin
            mem_we     = 1'b1;
            mem_wdata  = prod[7:0];
            count_next = cnt_m1;
          end
          default: begin
            if (right_val == 8'd0) begin
              if (err == STS_OK) err_next = STS_DIVZ;
            end else begin
              neg_next      = mem_rdata[7] ^ right_val[7];
              dvs_next      = right_mag;
              rem_next      = '0;
              quot_next     = left_mag;
              div_step_next = '0;
              state_next    = ST_DIV;
            end
          end
        endcase
      end
      ST_DIV: begin
        rem_next      = div_ge ? div_diff[7:0] : div_sh[7:0];
        quot_next     = quot_step;
        div_step_next = div_step + 3'd1;
        if (div_step == 3'd7) begin
          mem_we     = 1'b1;
          mem_wdata  = div_res;
          count_next = cnt_m1;
          state_next = last ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        if (count == '0) begin
          out_value_next  = '0;
          out_status_next = (err != STS_OK) ? err : STS_EMPTY;
          out_final_next  = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = ST_EMIT_OUT;
        end else begin
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        out_value_next  = mem_rdata;
        out_status_next = err;
        out_final_next  = (count == CW'(1));
        out_valid_next  = 1'b1;
        state_next      = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (!result_stall) begin
          out_valid_next = 1'b0;
          if (out_final) begin
            count_next = '0;
            err_next   = STS_OK;
            state_next = ST_IDLE;
          end else begin
            count_next = cnt_m1;
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("Stack count exceeds the stack depth.");

  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_EMIT_OUT))
    else $error("Result is valid outside the emit phase.");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_stall && out_final) |=> (count == '0 && err == STS_OK))
    else $error("Stack or error not cleared after the final transfer.");

  a_div_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DIV) |-> (div_step == 3'd0))
    else $error("Divider step counter is active outside a division.");

  a_no_write_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_RD || state == ST_EMIT_LD || state == ST_EMIT_OUT) |-> !mem_we)
    else $error("Stack written during the emit phase.");
`endif

endmodule
